// ----- sv/ssrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper speed ramp controller package
// Shared types, constants and a lookup function for the speed ramp controller.
// ----------------------------------------------------------------------------
package ssrc_pkg;

    localparam int DEF_MAX_SPEED_RPM      = 600;
    localparam int DEF_FULL_STEPS_PER_REV = 200;
    localparam int DEF_SPEED_INCREMENT    = 10;
    localparam int DEF_FRAC_BITS          = 16;

    localparam int US_PER_MIN    = 60000000;
    localparam int US_PER_SEC    = 1000000;
    localparam int PERIOD_LIMIT  = 1000000;
    localparam int TARGET_RESET  = 60;
    localparam int ACCEL_RESET   = 120;

    localparam int ACCEL_W  = 16;
    localparam int ELAPSED_W = 20;
    localparam int PERIOD_W = 20;
    localparam int RPM_W    = 10;
    localparam int CODE_W   = 3;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_CW     = 2'd1,
        ACT_CCW    = 2'd2,
        ACT_BUTTON = 2'd3
    } action_t;

    typedef enum logic {
        REG_ACCEL_RATE = 1'b0,
        REG_DIRECTION  = 1'b1
    } reg_index_t;

    localparam logic [CODE_W-1:0] MODE_FULL      = 3'd0;
    localparam logic [CODE_W-1:0] MODE_HALF      = 3'd1;
    localparam logic [CODE_W-1:0] MODE_QUARTER   = 3'd2;
    localparam logic [CODE_W-1:0] MODE_EIGHTH    = 3'd3;
    localparam logic [CODE_W-1:0] MODE_SIXTEENTH = 3'd4;

    localparam logic [2:0] PIN_SIXTEENTH = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP_LOAD,
        ST_RAMP_DIV,
        ST_RAMP_UPD,
        ST_PER_MUL,
        ST_PER_LOAD,
        ST_PER_DIV,
        ST_OUT
    } state_t;

    function automatic logic [2:0] pin_levels(input logic [CODE_W-1:0] code);
        logic [2:0] pins;
        unique case (code)
            MODE_FULL:      pins = 3'd0;
            MODE_HALF:      pins = 3'd1;
            MODE_QUARTER:   pins = 3'd2;
            MODE_EIGHTH:    pins = 3'd3;
            MODE_SIXTEENTH: pins = PIN_SIXTEENTH;
            default:        pins = 3'd0;
        endcase
        return pins;
    endfunction

endpackage

// ----- sv/stepper_speed_ramp_controller_top.sv -----
// ----------------------------------------------------------------------------
// Stepper speed ramp controller
// Ramps a fixed-point shaft speed toward an encoder-set target and reports the
// step pulse period for the selected microstep mode.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result per request.
// A tick with nonzero elapsed time makes two passes through the shared one
// bit per cycle restoring divider: FRAC_BITS + 36 steps for the ramp
// increment and FRAC_BITS + 26 steps for the step period. Other requests
// make only the period pass. When the ramped speed is zero the period
// division is skipped. The result becomes valid in the same cycle that the
// next request can be accepted. A new request is taken as soon as the
// previous result sits in the output register, even while that result waits
// to be taken; the request behind it then holds in ST_OUT until that result
// is taken.
module stepper_speed_ramp_controller_top #(
    parameter int MAX_SPEED_RPM      = ssrc_pkg::DEF_MAX_SPEED_RPM,
    parameter int FULL_STEPS_PER_REV = ssrc_pkg::DEF_FULL_STEPS_PER_REV,
    parameter int SPEED_INCREMENT    = ssrc_pkg::DEF_SPEED_INCREMENT,
    parameter int FRAC_BITS          = ssrc_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [ssrc_pkg::ACCEL_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic [ssrc_pkg::ELAPSED_W-1:0]  elapsed_us,
    input  logic                            other_line_high,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssrc_pkg::PERIOD_W-1:0]   step_period_us,
    output logic [ssrc_pkg::RPM_W-1:0]      target_rpm,
    output logic [ssrc_pkg::RPM_W-1:0]      current_rpm,
    output logic [ssrc_pkg::CODE_W-1:0]     microstep_code,
    output logic [2:0]                      mode_pins,
    output logic                            direction_out
);
    import ssrc_pkg::*;

    localparam int SPW = RPM_W + FRAC_BITS;
    localparam int PRW = ACCEL_W + ELAPSED_W;
    localparam int NW  = PRW + FRAC_BITS;
    localparam int MW  = SPW + 10;
    localparam int DW  = MW + 4;
    localparam int PNW = 26 + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);

    localparam logic [RPM_W-1:0] MAX_RPM_W = RPM_W'(MAX_SPEED_RPM);
    localparam logic [RPM_W:0]   INC_W     = (RPM_W + 1)'(SPEED_INCREMENT);
    localparam logic [9:0]       FSPR_W    = 10'(FULL_STEPS_PER_REV);
    localparam logic [25:0]      US_MIN_W  = 26'(US_PER_MIN);
    localparam logic [SPW-1:0]   SPEED_CAP = {MAX_RPM_W, {FRAC_BITS{1'b0}}};
    localparam logic [RPM_W-1:0] TGT_RESET =
        (TARGET_RESET > MAX_SPEED_RPM) ? MAX_RPM_W : RPM_W'(TARGET_RESET);

    state_t                 state_reg, state_next;
    logic [SPW-1:0]         cur_reg, cur_next;
    logic [RPM_W-1:0]       target_reg, target_next;
    logic [CODE_W-1:0]      mode_reg, mode_next;
    logic [ACCEL_W-1:0]     accel_reg;
    logic                   dir_reg;
    logic [PRW-1:0]         prod_reg, prod_next;
    logic [MW-1:0]          den_reg, den_next;
    logic [NW-1:0]          num_reg, num_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          div_reg, div_next;
    logic [NW-1:0]          quo_reg, quo_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   stop_reg, stop_next;

    logic                   out_valid_reg, out_valid_next;
    logic [PERIOD_W-1:0]    period_reg;
    logic [RPM_W-1:0]       target_out_reg;
    logic [RPM_W-1:0]       current_out_reg;
    logic [CODE_W-1:0]      code_out_reg;
    logic [2:0]             pins_out_reg;
    logic                   dir_out_reg;

    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic                   ramp_needed;
    logic [ACCEL_W-1:0]     accel_eff;
    logic [RPM_W:0]         target_up;
    logic [SPW-1:0]         speed_sel;
    logic [SPW-1:0]         target_fix;
    logic                   ramp_up;
    logic [SPW-1:0]         speed_gap;
    logic                   snap;
    logic [DW:0]            trial;
    logic [DW:0]            trial_diff;
    logic                   trial_ge;
    logic [PERIOD_W-1:0]    period_val;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_OUT) && out_free;

    assign ramp_needed = (action_t'(action) == ACT_TICK) && (elapsed_us != '0);
    assign accel_eff   = (accel_reg == '0) ? ACCEL_W'(1) : accel_reg;
    assign target_up   = {1'b0, target_reg} + INC_W;
    assign speed_sel   = (cur_reg > SPEED_CAP) ? SPEED_CAP : cur_reg;
    assign target_fix  = {target_reg, {FRAC_BITS{1'b0}}};
    assign ramp_up     = (target_fix >= cur_reg);
    assign speed_gap   = ramp_up ? (target_fix - cur_reg) : (cur_reg - target_fix);
    assign snap        = (NW'(speed_gap) <= quo_reg);

    assign trial      = {rem_reg, num_reg[NW-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign trial_ge   = (trial >= {1'b0, div_reg});

    assign period_val = stop_reg ? '0 :
                        (quo_reg > NW'(PERIOD_LIMIT)) ? PERIOD_W'(PERIOD_LIMIT) :
                        quo_reg[PERIOD_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ramp_needed ? ST_RAMP_LOAD : ST_PER_MUL;
                end
            end
            ST_RAMP_LOAD:
            begin
                state_next = ST_RAMP_DIV;
            end
            ST_RAMP_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_RAMP_UPD;
                end
            end
            ST_RAMP_UPD:
            begin
                state_next = ST_PER_MUL;
            end
            ST_PER_MUL:
            begin
                state_next = (speed_sel == '0) ? ST_OUT : ST_PER_LOAD;
            end
            ST_PER_LOAD:
            begin
                state_next = ST_PER_DIV;
            end
            ST_PER_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next    = cur_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        prod_next   = prod_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        stop_next   = stop_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    prod_next = accel_eff * elapsed_us;
                    case (action_t'(action))
                        ACT_CW:
                        begin
                            if (!other_line_high)
                            begin
                                target_next = (target_reg > INC_W[RPM_W-1:0]) ?
                                              (target_reg - INC_W[RPM_W-1:0]) : '0;
                            end
                        end
                        ACT_CCW:
                        begin
                            if (!other_line_high)
                            begin
                                target_next = (target_up > {1'b0, MAX_RPM_W}) ?
                                              MAX_RPM_W : target_up[RPM_W-1:0];
                            end
                        end
                        ACT_BUTTON:
                        begin
                            mode_next = (mode_reg >= MODE_SIXTEENTH) ?
                                        MODE_FULL : (mode_reg + CODE_W'(1));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RAMP_LOAD:
            begin
                num_next = {prod_reg, {FRAC_BITS{1'b0}}};
                div_next = DW'(US_PER_SEC);
                rem_next = '0;
                quo_next = '0;
                cnt_next = CW'(NW);
            end
            ST_RAMP_DIV, ST_PER_DIV:
            begin
                num_next = {num_reg[NW-2:0], 1'b0};
                rem_next = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], trial_ge};
                cnt_next = cnt_reg - CW'(1);
            end
            ST_RAMP_UPD:
            begin
                if (snap)
                begin
                    cur_next = target_fix;
                end
                else if (ramp_up)
                begin
                    cur_next = cur_reg + quo_reg[SPW-1:0];
                end
                else
                begin
                    cur_next = cur_reg - quo_reg[SPW-1:0];
                end
            end
            ST_PER_MUL:
            begin
                den_next  = speed_sel * FSPR_W;
                stop_next = (speed_sel == '0);
            end
            ST_PER_LOAD:
            begin
                num_next = {US_MIN_W, {(FRAC_BITS + NW - PNW){1'b0}}};
                div_next = DW'(den_reg) << mode_reg;
                rem_next = '0;
                quo_next = '0;
                cnt_next = CW'(PNW);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            target_reg    <= TGT_RESET;
            mode_reg      <= MODE_HALF;
            accel_reg     <= ACCEL_W'(ACCEL_RESET);
            dir_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            target_reg    <= target_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_ACCEL_RATE: accel_reg <= cfg_data;
                    REG_DIRECTION:  dir_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        stop_reg <= stop_next;
        if (out_load)
        begin
            period_reg      <= period_val;
            target_out_reg  <= target_reg;
            current_out_reg <= cur_reg[SPW-1:FRAC_BITS];
            code_out_reg    <= mode_reg;
            pins_out_reg    <= pin_levels(mode_reg);
            dir_out_reg     <= dir_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_period_us = period_reg;
    assign target_rpm     = target_out_reg;
    assign current_rpm    = current_out_reg;
    assign microstep_code = code_out_reg;
    assign mode_pins      = pins_out_reg;
    assign direction_out  = dir_out_reg;

endmodule

// ----- sv/ssrc_checker.sv -----
// ----------------------------------------------------------------------------
// Stepper speed ramp controller checker
// Port-level assertions for the speed ramp controller, bound to the top level.
// ----------------------------------------------------------------------------
module ssrc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [ssrc_pkg::PERIOD_W-1:0]   step_period_us,
    input logic [ssrc_pkg::RPM_W-1:0]      current_rpm,
    input logic [ssrc_pkg::CODE_W-1:0]     microstep_code,
    input logic [2:0]                      mode_pins
);
    import ssrc_pkg::*;

    // A waiting result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // One request is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((microstep_code == MODE_SIXTEENTH && mode_pins == PIN_SIXTEENTH) ||
                       (microstep_code < MODE_SIXTEENTH && mode_pins == microstep_code)))
        else $error("mode pins do not match microstep code");

    // A running motor always has a step period.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && current_rpm != '0 |-> step_period_us != '0)
        else $error("zero period while speed is nonzero");

endmodule

bind stepper_speed_ramp_controller_top ssrc_checker u_checker (.*);
